>>> sv/lzcbc_pkg.sv
// Shared types and constants for the LZ code bit cost block.
package lzcbc_pkg;

  typedef enum logic [1:0] {
    MODE_MEGALZ = 2'd0,
    MODE_HRUM   = 2'd1,
    MODE_HRUST  = 2'd2,
    MODE_ZX7    = 2'd3
  } packer_mode_t;

  localparam int CfgIndexW = 1;
  localparam int CfgDataW  = 17;

  localparam logic [CfgIndexW-1:0] CFG_PACKER_MODE    = 1'b0;
  localparam logic [CfgIndexW-1:0] CFG_PRELOAD_LENGTH = 1'b1;

  typedef struct packed {
    logic signed [17:0] code_length;
    logic signed [16:0] displacement;
    logic [23:0]        position;
  } code_item_t;

  typedef struct packed {
    logic [8:0] bit_cost;
    logic       code_invalid;
  } cost_item_t;

  typedef struct packed {
    packer_mode_t packer_mode;
    logic [16:0]  preload_length;
  } cost_cfg_t;

endpackage

>>> sv/lzcbc_if.sv
// Valid/ready channel interfaces for code items and cost results.
interface lzcbc_in_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] code_length;
  logic signed [16:0] displacement;
  logic [23:0]        position;

  modport source (output valid, output code_length, output displacement, output position,
                  input ready);
  modport sink (input valid, input code_length, input displacement, input position,
                output ready);
endinterface

interface lzcbc_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] bit_cost;
  logic       code_invalid;

  modport source (output valid, output bit_cost, output code_invalid, input ready);
  modport sink (input valid, input bit_cost, input code_invalid, output ready);
endinterface

>>> sv/lzcbc_cfg.sv
// Configuration registers: packer mode and preload length.
module lzcbc_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lzcbc_pkg::CfgIndexW-1:0]   cfg_index,
  input  logic [lzcbc_pkg::CfgDataW-1:0]    cfg_wdata,
  output lzcbc_pkg::cost_cfg_t              cfg
);
  import lzcbc_pkg::*;

  packer_mode_t mode_r;
  logic [16:0]  preload_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_MEGALZ;
      preload_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PACKER_MODE:    mode_r    <= packer_mode_t'(cfg_wdata[1:0]);
        CFG_PRELOAD_LENGTH: preload_r <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  assign cfg.packer_mode    = mode_r;
  assign cfg.preload_length = preload_r;

endmodule

>>> sv/lzcbc_cost.sv
// Combinational bit cost of one code in the selected packer format.
module lzcbc_cost (
  input  lzcbc_pkg::code_item_t item,
  input  lzcbc_pkg::cost_cfg_t  cfg,
  output lzcbc_pkg::cost_item_t result
);
  import lzcbc_pkg::*;

  // Twice the bit length of v.
  function automatic logic [5:0] twice_bitlen(input logic [15:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) n = 6'(2 * (i + 1));
    end
    return n;
  endfunction

  // Length bits shared by the hrum-like and hrust-like formats for lengths 4 to 15.
  function automatic logic [8:0] mid_len_bits(input logic [3:0] l);
    logic [8:0] n;
    case (l) inside
      [4'd4:4'd5]:   n = 9'd5;
      [4'd6:4'd8]:   n = 9'd7;
      [4'd9:4'd11]:  n = 9'd9;
      default:       n = 9'd11;
    endcase
    return n;
  endfunction

  logic signed [17:0] len;
  logic signed [16:0] d;
  logic signed [25:0] rel;
  logic signed [17:0] len_m1;
  logic [7:0]         mz_len;
  logic [8:0]         mz_bits;
  logic [8:0]         zx_bits;
  logic [2:0]         far_extra;
  logic [8:0]         c_megalz;
  logic [8:0]         c_hrum;
  logic [8:0]         c_hrust;
  logic [8:0]         c_zx7;
  logic [8:0]         c;

  assign len    = item.code_length;
  assign d      = item.displacement;
  assign len_m1 = len - 18'sd1;
  assign mz_len = (len[7:0] - 8'd2) >> 1;
  assign mz_bits = {3'b000, twice_bitlen({8'b0, mz_len})};
  assign zx_bits = {3'b000, twice_bitlen(len_m1[15:0])};
  assign rel = $signed({2'b00, item.position}) - $signed({9'b0, cfg.preload_length});

  always_comb begin
    far_extra = '0;
    for (int k = 0; k < 6; k++) begin
      if (rel > $signed(26'(1024 << k))) far_extra = far_extra + 3'd1;
    end
  end

  always_comb begin
    c_megalz = '0;
    if (len == 18'sd1) begin
      if (d == 17'sd0) c_megalz = 9'd9;
      else if (d >= -8 && d <= -1) c_megalz = 9'd6;
    end else if (len == 18'sd2) begin
      if (d >= -256 && d <= -1) c_megalz = 9'd11;
    end else if (len == 18'sd3) begin
      if (d >= -256 && d <= -1) c_megalz = 9'd12;
      else if (d >= -4352 && d < -256) c_megalz = 9'd16;
    end else if (len >= 4 && len <= 255) begin
      if (d >= -256 && d <= -1) c_megalz = mz_bits + 9'd12;
      else if (d >= -4352 && d < -256) c_megalz = mz_bits + 9'd16;
    end
  end

  always_comb begin
    logic [8:0] lb;
    c_hrum = '0;
    lb     = 9'd3;
    if (len >= 4 && len <= 15) lb = mid_len_bits(len[3:0]);
    else if (len > 15) lb = 9'd13;
    if (len == 18'sd1) begin
      if (d == 17'sd0) c_hrum = 9'd9;
      else if (d >= -8 && d <= -1) c_hrum = 9'd6;
    end else if (len == 18'sd2) begin
      if (d >= -256 && d <= -1) c_hrum = 9'd11;
    end else if (len >= 3 && len <= 255) begin
      if (d >= -256 && d <= -1) c_hrum = lb + 9'd9;
      else if (d >= -4096 && d < -256) c_hrum = lb + 9'd13;
    end
  end

  always_comb begin
    logic [8:0] lb;
    c_hrust = '0;
    if (len == 18'sd3) lb = 9'd3;
    else if (len <= 15) lb = mid_len_bits(len[3:0]);
    else if (len <= 127) lb = 9'd14;
    else lb = 9'd22;
    if (d == 17'sd0) begin
      if (len == 18'sd1) c_hrust = 9'd9;
      else if (len >= 12 && len <= 42 && !len[0]) c_hrust = 9'd11 + {len[5:0], 3'b000};
    end else if (len == -18'sd3) begin
      if (d >= -16 && d <= -1) c_hrust = 9'd18;
      else if (d >= -79 && d < -16) c_hrust = 9'd21;
    end else if (len == 18'sd1) begin
      if (d >= -8 && d <= -1) c_hrust = 9'd6;
    end else if (len == 18'sd2) begin
      if (d >= -32 && d <= -1) c_hrust = 9'd10;
      else if (d >= -768 && d < -32) c_hrust = 9'd13;
    end else if (len >= 3 && len <= 3839 && d <= -1) begin
      if (d >= -32) c_hrust = lb + 9'd7;
      else if (d >= -512) c_hrust = lb + 9'd10;
      else c_hrust = lb + 9'd12 + {6'b0, far_extra};
    end
  end

  always_comb begin
    c_zx7 = '0;
    if (len == 18'sd1) begin
      if (d == 17'sd0) c_zx7 = 9'd9;
    end else if (len >= 2 && len <= 65536) begin
      if (d >= -128 && d <= -1) c_zx7 = zx_bits + 9'd8;
      else if (d >= -2176 && d < -128) c_zx7 = zx_bits + 9'd12;
    end
  end

  always_comb begin
    case (cfg.packer_mode)
      MODE_MEGALZ: c = c_megalz;
      MODE_HRUM:   c = c_hrum;
      MODE_HRUST:  c = c_hrust;
      MODE_ZX7:    c = c_zx7;
      default:     c = c_zx7;
    endcase
  end

  assign result.bit_cost     = c;
  assign result.code_invalid = (c == 9'd0);

endmodule

>>> sv/lz_code_bit_cost.sv
// Top level of the LZ code bit cost block: input register, cost logic, result register.
// One code can be accepted in every cycle. A transferred code is held in the input register,
// costed combinationally from it, and its result is registered in the result register,
// which drives the output. The input register still takes a code while the result
// register waits if it is empty, so at most two codes are in flight and the input stalls
// only when both registers are full and the output is not ready. packer_mode selects the
// format and preload_length shifts the far-displacement cost of the hrust-like format;
// write them only while no code is in flight.
module lz_code_bit_cost (
  input  logic                              clk,
  input  logic                              rst_n,
  lzcbc_in_if.sink                          in_chan,
  lzcbc_out_if.source                       out_chan,
  input  logic                              cfg_we,
  input  logic [lzcbc_pkg::CfgIndexW-1:0]   cfg_index,
  input  logic [lzcbc_pkg::CfgDataW-1:0]    cfg_wdata
);
  import lzcbc_pkg::*;

  cost_cfg_t  cfg;
  code_item_t item_r;
  code_item_t item_nxt;
  cost_item_t cost;
  cost_item_t res_r;
  logic       in_vld_r;
  logic       out_vld_r;
  logic       s2_ready;
  logic       s1_ready;

  lzcbc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lzcbc_cost u_cost (
    .item   (item_r),
    .cfg    (cfg),
    .result (cost)
  );

  assign s2_ready = !out_vld_r || out_chan.ready;
  assign s1_ready = !in_vld_r || s2_ready;

  assign item_nxt.code_length  = in_chan.code_length;
  assign item_nxt.displacement = in_chan.displacement;
  assign item_nxt.position     = in_chan.position;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (s1_ready) in_vld_r <= in_chan.valid;
      if (s2_ready) out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_chan.valid) item_r <= item_nxt;
    if (s2_ready && in_vld_r) res_r <= cost;
  end

  assign in_chan.ready         = s1_ready;
  assign out_chan.valid        = out_vld_r;
  assign out_chan.bit_cost     = res_r.bit_cost;
  assign out_chan.code_invalid = res_r.code_invalid;

endmodule

>>> sv/lzcbc_chk.sv
// Port-level checks for the LZ code bit cost block, bound to its top level.
module lzcbc_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [8:0] bit_cost,
  input logic       code_invalid
);

  // A result is flagged invalid exactly when its cost is zero.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (code_invalid == (bit_cost == 9'd0)))
    else $error("code_invalid disagrees with bit_cost");

  // No format costs more than 347 bits.
  a_cost_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (bit_cost <= 9'd347))
    else $error("bit_cost out of range");

  // Nothing is shown in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // An input transfer while the output drains, with the output still ready after it, leaves a result.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && out_valid && out_ready) ##1 (out_ready) |=> out_valid)
    else $error("accepted code produced no result");

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(bit_cost) && $stable(code_invalid)))
    else $error("stalled result changed");

endmodule

bind lz_code_bit_cost lzcbc_chk u_lzcbc_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .bit_cost     (out_chan.bit_cost),
  .code_invalid (out_chan.code_invalid)
);
